// File: sv/imu_gravity_and_world_accel_macros.svh
// assertion helpers for the gravity and world acceleration block
`ifndef IMU_GRAVITY_AND_WORLD_ACCEL_MACROS_SVH
`define IMU_GRAVITY_AND_WORLD_ACCEL_MACROS_SVH

// same-cycle implication
`define IGWA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("igwa same-cycle check failed");

// next-cycle implication
`define IGWA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("igwa next-cycle check failed");

`endif

// File: sv/igwa_pkg.sv
`default_nettype none

package igwa_pkg;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec3_t;

  typedef struct packed {
    quat_t q;
    vec3_t g;
    vec3_t l;
  } rot_in_t;

  typedef struct packed {
    vec3_t wa;
    vec3_t l;
    vec3_t g;
  } rot_out_t;

  localparam int unsigned GRAV_XY_SHIFT = 13;
  localparam int unsigned GRAV_Z_SHIFT  = 14;
  localparam int unsigned LIN_XY_SHIFT  = 14;
  localparam int unsigned LIN_Z_SHIFT   = 15;
  localparam int unsigned WORLD_SHIFT   = 28;

  function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    mul16 = 32'(a) * 32'(b);
  endfunction

  function automatic logic signed [49:0] mul34x16(input logic signed [33:0] a,
                                                  input logic signed [15:0] b);
    mul34x16 = 50'(a) * 50'(b);
  endfunction

  // arithmetic shift that rounds toward zero
  function automatic logic signed [55:0] trunc_shr(input logic signed [55:0] v,
                                                   input int unsigned sh);
    logic signed [55:0] bias;
    bias = (56'sd1 <<< sh) - 56'sd1;
    if (v < 56'sd0) begin
      trunc_shr = (v + bias) >>> sh;
    end else begin
      trunc_shr = v >>> sh;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
    if (v > 56'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -56'sd32768) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = 16'(v);
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/imu_gravity_and_world_accel.sv
// a result is registered in stages st1 to st3 and then in the igwa_rotate stages before it is presented
// throughput: one transaction per cycle unless the output stalls, set by the registered multiplier stages
// a stalled output holds its stage; bubbles ahead of it still accept input
// reset (rst, synchronous, active high) clears the stage valid bits only
`default_nettype none

`include "imu_gravity_and_world_accel_macros.svh"

module imu_gravity_and_world_accel import igwa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // gravity_x/y/z, linear_accel_x/y/z, world_accel_x/y/z
  output logic [143:0]      m_tdata
);

  quat_t in_q;
  vec3_t in_a;

  logic st1_valid, st2_valid, st3_valid;
  logic st1_ready, st2_ready, st3_ready;
  logic rot_ready;

  quat_t st1_q, st2_q;
  vec3_t st1_a, st2_a;

  logic signed [31:0] p_wy, p_xz, p_wx, p_yz, p_ww, p_xx, p_yy, p_zz;
  logic signed [32:0] hx, hy;
  logic signed [33:0] fz;

  vec3_t g_next, l_next;
  rot_in_t  st3_data;
  rot_out_t rot_out;

  always_comb begin
    in_q.w = s_tdata[15:0];
    in_q.x = s_tdata[31:16];
    in_q.y = s_tdata[47:32];
    in_q.z = s_tdata[63:48];
    in_a.x = s_tdata[79:64];
    in_a.y = s_tdata[95:80];
    in_a.z = s_tdata[111:96];
  end

  assign st3_ready = !st3_valid || rot_ready;
  assign st2_ready = !st2_valid || st3_ready;
  assign st1_ready = !st1_valid || st2_ready;
  assign s_tready  = st1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
    end else begin
      if (st1_ready) st1_valid <= s_tvalid;
      if (st2_ready) st2_valid <= st1_valid;
      if (st3_ready) st3_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_ready && s_tvalid) begin
      st1_q <= in_q;
      st1_a <= in_a;
      p_wy  <= mul16(in_q.w, in_q.y);
      p_xz  <= mul16(in_q.x, in_q.z);
      p_wx  <= mul16(in_q.w, in_q.x);
      p_yz  <= mul16(in_q.y, in_q.z);
      p_ww  <= mul16(in_q.w, in_q.w);
      p_xx  <= mul16(in_q.x, in_q.x);
      p_yy  <= mul16(in_q.y, in_q.y);
      p_zz  <= mul16(in_q.z, in_q.z);
    end
  end

  // gravity numerators at 2^-28
  always_ff @(posedge clk) begin
    if (st2_ready && st1_valid) begin
      st2_q <= st1_q;
      st2_a <= st1_a;
      hx    <= 33'(p_xz) - 33'(p_wy);
      hy    <= 33'(p_wx) + 33'(p_yz);
      fz    <= 34'(p_ww) - 34'(p_xx) - 34'(p_yy) + 34'(p_zz);
    end
  end

  always_comb begin
    logic signed [55:0] lxn, lyn, lzn;
    lxn = (56'(st2_a.x) <<< LIN_XY_SHIFT) - 56'(hx);
    lyn = (56'(st2_a.y) <<< LIN_XY_SHIFT) - 56'(hy);
    lzn = (56'(st2_a.z) <<< LIN_Z_SHIFT) - 56'(fz);
    g_next.x = sat16(trunc_shr(56'(hx), GRAV_XY_SHIFT));
    g_next.y = sat16(trunc_shr(56'(hy), GRAV_XY_SHIFT));
    g_next.z = sat16(trunc_shr(56'(fz), GRAV_Z_SHIFT));
    l_next.x = sat16(trunc_shr(lxn, LIN_XY_SHIFT));
    l_next.y = sat16(trunc_shr(lyn, LIN_XY_SHIFT));
    l_next.z = sat16(trunc_shr(lzn, LIN_Z_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (st3_ready && st2_valid) begin
      st3_data.q <= st2_q;
      st3_data.g <= g_next;
      st3_data.l <= l_next;
    end
  end

  igwa_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st3_valid),
    .in_ready  (rot_ready),
    .in_data   (st3_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (rot_out)
  );

  assign m_tdata = {rot_out.wa.z, rot_out.wa.y, rot_out.wa.x,
                    rot_out.l.z, rot_out.l.y, rot_out.l.x,
                    rot_out.g.z, rot_out.g.y, rot_out.g.x};

  `IGWA_ASSERT_IMP(a_accept_when_empty, clk, rst, !st1_valid, s_tready)
  `IGWA_ASSERT_NXT(a_accept_lands, clk, rst, s_tvalid && s_tready, st1_valid)
  `IGWA_ASSERT_IMP(a_stall_only_when_full, clk, rst, st1_valid && !s_tready,
                   st2_valid && st3_valid && !rot_ready)

endmodule

`default_nettype wire

// File: sv/igwa_rotate.sv
`default_nettype none

module igwa_rotate import igwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rot_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rot_out_t      out_data
);

  logic [4:0] vld;
  logic [4:0] rdy;

  // stage payloads
  quat_t r1_q, r2_q;
  vec3_t r1_g, r2_g, r3_g, r4_g;
  vec3_t r1_l, r2_l, r3_l, r4_l;

  logic signed [31:0] p_xlx, p_yly, p_zlz, p_wlx, p_ylz, p_zly;
  logic signed [31:0] p_wly, p_xlz, p_zlx, p_wlz, p_xly, p_ylx;

  logic signed [33:0] tw, tx, ty, tz;

  logic signed [49:0] m_twx, m_txw, m_tyz, m_tzy;
  logic signed [49:0] m_twy, m_txz, m_tyw, m_tzx;
  logic signed [49:0] m_twz, m_txy, m_tyx, m_tzw;

  logic signed [51:0] rx, ry, rz;

  rot_out_t out_reg;

  always_comb begin
    rdy[4] = !vld[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[4];
  assign out_data  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // q times (0, l): single products
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      r1_q  <= in_data.q;
      r1_g  <= in_data.g;
      r1_l  <= in_data.l;
      p_xlx <= mul16(in_data.q.x, in_data.l.x);
      p_yly <= mul16(in_data.q.y, in_data.l.y);
      p_zlz <= mul16(in_data.q.z, in_data.l.z);
      p_wlx <= mul16(in_data.q.w, in_data.l.x);
      p_ylz <= mul16(in_data.q.y, in_data.l.z);
      p_zly <= mul16(in_data.q.z, in_data.l.y);
      p_wly <= mul16(in_data.q.w, in_data.l.y);
      p_xlz <= mul16(in_data.q.x, in_data.l.z);
      p_zlx <= mul16(in_data.q.z, in_data.l.x);
      p_wlz <= mul16(in_data.q.w, in_data.l.z);
      p_xly <= mul16(in_data.q.x, in_data.l.y);
      p_ylx <= mul16(in_data.q.y, in_data.l.x);
    end
  end

  // q times (0, l): sums
  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      r2_q <= r1_q;
      r2_g <= r1_g;
      r2_l <= r1_l;
      tw   <= -34'(p_xlx) - 34'(p_yly) - 34'(p_zlz);
      tx   <= 34'(p_wlx) + 34'(p_ylz) - 34'(p_zly);
      ty   <= 34'(p_wly) - 34'(p_xlz) + 34'(p_zlx);
      tz   <= 34'(p_wlz) + 34'(p_xly) - 34'(p_ylx);
    end
  end

  // t times conj(q): single products
  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      r3_g  <= r2_g;
      r3_l  <= r2_l;
      m_twx <= mul34x16(tw, r2_q.x);
      m_txw <= mul34x16(tx, r2_q.w);
      m_tyz <= mul34x16(ty, r2_q.z);
      m_tzy <= mul34x16(tz, r2_q.y);
      m_twy <= mul34x16(tw, r2_q.y);
      m_txz <= mul34x16(tx, r2_q.z);
      m_tyw <= mul34x16(ty, r2_q.w);
      m_tzx <= mul34x16(tz, r2_q.x);
      m_twz <= mul34x16(tw, r2_q.z);
      m_txy <= mul34x16(tx, r2_q.y);
      m_tyx <= mul34x16(ty, r2_q.x);
      m_tzw <= mul34x16(tz, r2_q.w);
    end
  end

  // t times conj(q): sums
  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      r4_g <= r3_g;
      r4_l <= r3_l;
      rx   <= 52'(m_txw) - 52'(m_twx) - 52'(m_tyz) + 52'(m_tzy);
      ry   <= 52'(m_txz) - 52'(m_twy) + 52'(m_tyw) - 52'(m_tzx);
      rz   <= 52'(m_tyx) - 52'(m_twz) - 52'(m_txy) + 52'(m_tzw);
    end
  end

  // scale back, round toward zero, saturate
  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      out_reg.g    <= r4_g;
      out_reg.l    <= r4_l;
      out_reg.wa.x <= sat16(trunc_shr(56'(rx), WORLD_SHIFT));
      out_reg.wa.y <= sat16(trunc_shr(56'(ry), WORLD_SHIFT));
      out_reg.wa.z <= sat16(trunc_shr(56'(rz), WORLD_SHIFT));
    end
  end

endmodule

`default_nettype wire

// File: test/igwa_rotation_checker.sv
`timescale 1ns / 100ps

module igwa_rotation_checker import igwa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
  input  wire logic [111:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  // gravity_x/y/z, linear_accel_x/y/z, world_accel_x/y/z
  input  wire logic [143:0] m_tdata,
  output int                mismatches,
  output int                results_seen,
  output int                awaited
);

  typedef struct packed {
    vec3_t accel;
    quat_t q;
  } packet_t;

  localparam longint Q14 = 64'sd16384;
  localparam longint Q15 = 64'sd32768;
  localparam longint Q28 = 64'sd268435456;

  rot_out_t pending_results[$];

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic rot_out_t predict_rotation(input packet_t p);
    longint w, x, y, z, ax, ay, az;
    longint hx, hy, fz, lx, ly, lz;
    longint tw, tx, ty, tz, rx, ry, rz;
    rot_out_t r;
    w  = p.q.w;
    x  = p.q.x;
    y  = p.q.y;
    z  = p.q.z;
    ax = p.accel.x;
    ay = p.accel.y;
    az = p.accel.z;
    hx = x * z - w * y;
    hy = w * x + y * z;
    fz = w * w - x * x - y * y + z * z;
    r.g.x = clip16((2 * hx) / Q14);
    r.g.y = clip16((2 * hy) / Q14);
    r.g.z = clip16(fz / Q14);
    r.l.x = clip16((ax * Q14 - hx) / Q14);
    r.l.y = clip16((ay * Q14 - hy) / Q14);
    r.l.z = clip16((az * Q15 - fz) / Q15);
    // rotation uses the saturated linear acceleration
    lx = r.l.x;
    ly = r.l.y;
    lz = r.l.z;
    tw = -x * lx - y * ly - z * lz;
    tx = w * lx + y * lz - z * ly;
    ty = w * ly - x * lz + z * lx;
    tz = w * lz + x * ly - y * lx;
    rx = -tw * x + tx * w - ty * z + tz * y;
    ry = -tw * y + tx * z + ty * w - tz * x;
    rz = -tw * z - tx * y + ty * x + tz * w;
    r.wa.x = clip16(rx / Q28);
    r.wa.y = clip16(ry / Q28);
    r.wa.z = clip16(rz / Q28);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    rot_out_t want;
    rot_out_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $error("result transaction with nothing outstanding: %h", m_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("gravity_x", want.g.x, got.g.x);
          check_field("gravity_y", want.g.y, got.g.y);
          check_field("gravity_z", want.g.z, got.g.z);
          check_field("linear_accel_x", want.l.x, got.l.x);
          check_field("linear_accel_y", want.l.y, got.l.y);
          check_field("linear_accel_z", want.l.z, got.l.z);
          check_field("world_accel_x", want.wa.x, got.wa.x);
          check_field("world_accel_y", want.wa.y, got.wa.y);
          check_field("world_accel_z", want.wa.z, got.wa.z);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_rotation(packet_t'(s_tdata)));
      end
      awaited = pending_results.size();
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import igwa_pkg::*;;

  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_PACKETS  = 1150;
  localparam int CHUNK           = 50;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
  logic [111:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // gravity_x/y/z, linear_accel_x/y/z, world_accel_x/y/z
  logic [143:0] m_tdata;

  int mismatches;
  int results_seen;
  int awaited;
  int packets_sent;
  int directed_sent;
  bit no_idle;
  bit hold_off;
  int longest_hold;

  imu_gravity_and_world_accel dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  igwa_rotation_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .awaited      (awaited)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] span(input int lim);
    return 16'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_packet(input logic [111:0] d);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    packets_sent++;
    @(negedge clk);
  endtask

  task automatic push_fields(input logic [15:0] w, x, y, z, ax, ay, az);
    quat_t q;
    vec3_t a;
    q.w = w;
    q.x = x;
    q.y = y;
    q.z = z;
    a.x = ax;
    a.y = ay;
    a.z = az;
    push_packet({a, q});
  endtask

  task automatic push_random_packet();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      // plausible orientation and acceleration
      push_fields(span(12000), span(12000), span(12000), span(12000),
                  span(20000), span(20000), span(20000));
    end else if (kind < 8) begin
      push_fields(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      push_fields(corner_value(), corner_value(), corner_value(), corner_value(),
                  corner_value(), corner_value(), corner_value());
    end
  endtask

  // result side
  initial begin
    int run;
    int gap;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        longest_hold = HOLD_OFF_CYCLES;
      end
      run = no_idle ? 1 : $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = idle_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    no_idle      = 1'b0;
    hold_off     = 1'b0;
    packets_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, axis turns, extremes, non-unit and tiny negative values
    push_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_fields(16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd8192);
    push_fields(16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -16'sd8192);
    push_fields(16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
    push_fields(16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    push_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_fields(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    push_fields(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    push_fields(16'd11585, 16'h0000, 16'h0000, 16'd11585, 16'd8192, 16'h0000, 16'h0000);
    push_fields(16'h0000, 16'd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd8192);
    push_fields(16'h0000, 16'h0000, 16'd16384, 16'h0000, 16'd4000, -16'sd4000, 16'd8192);
    push_fields(16'h0000, 16'h0000, 16'h0000, 16'd16384, -16'sd300, 16'd500, 16'd8192);
    push_fields(16'd8192, 16'h0000, 16'h0000, 16'h0000, 16'd1000, 16'd2000, 16'd3000);
    push_fields(-16'sd16384, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd8192, 16'h0000);
    push_fields(16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'hffff);
    push_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff);
    push_fields(16'd8192, 16'd8192, 16'd8192, 16'd8192, 16'd100, -16'sd200, 16'd300);
    push_fields(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_fields(16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'h0000);
    push_fields(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
    push_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa);
    directed_sent = packets_sent;

    for (int i = 0; i < RANDOM_PACKETS; i++) begin
      if (i % CHUNK == 0) begin
        no_idle = ((i / CHUNK) % 5 == 4);
        if (i == 2 * CHUNK) begin
          hold_off = 1'b1;
        end
      end
      push_random_packet();
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d packets (%0d directed, %0d random), checked %0d results",
             packets_sent, directed_sent, packets_sent - directed_sent, results_seen);
    $display("result side held off once for %0d cycles with input still offered",
             longest_hold);
    if (mismatches == 0 && awaited == 0 && results_seen == packets_sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: imu_gravity_and_world_accel.f
+incdir+sv
sv/igwa_pkg.sv
sv/igwa_rotate.sv
sv/imu_gravity_and_world_accel.sv
test/igwa_rotation_checker.sv
test/tb_top.sv
